// ===== src/mme_pkg.sv =====
// mme_pkg: shared types and constants of the matrix multiply engine
// transaction structs, kind and register index codes, datapath control struct
// no dependencies
`default_nettype none

package mme_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned CFG_W       = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned MAX_RESULTS = 64;
  localparam int unsigned CNT_W       = 7;

  localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

  typedef enum logic [1:0] {
    KIND_WR_A    = 2'd0,
    KIND_WR_B    = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS_A = 2'd0,
    CFG_INNER  = 2'd1,
    CFG_COLS_B = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]              kind;
    logic [POS_W-1:0]        row;
    logic [POS_W-1:0]        col;
    logic signed [DATA_W-1:0] value;
  } mme_in_t;

  typedef struct packed {
    logic [POS_W-1:0]        out_row;
    logic [POS_W-1:0]        out_col;
    logic signed [DATA_W-1:0] out_value;
    logic                    last;
    logic                    error;
  } mme_out_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             acc_last;
    logic             last;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } mac_ctl_t;

endpackage

`default_nettype wire

// ===== src/mme_mac.sv =====
// mme_mac: multiply, accumulate and saturate datapath of the engine
// depends on mme_pkg (mac_ctl_t, mme_out_t)
`default_nettype none

module mme_mac import mme_pkg::*; #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic signed [DATA_W-1:0] rd_a_i,
  input  wire logic signed [DATA_W-1:0] rd_b_i,
  input  wire mac_ctl_t                 ctl_i,
  output logic                          done_valid_o,
  output mme_out_t                      done_o
);

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned ACC_W  = PROD_W + $clog2(MAX_DIM);

  mac_ctl_t                  ctl_p_q, ctl_a_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   acc_d, acc_q;
  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-DATA_W:0]     hi_bits;
  logic                      fits;
  logic signed [DATA_W-1:0]  sat_value;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_p_q <= '0;
      ctl_a_q <= '0;
    end else begin
      ctl_p_q <= ctl_i;
      ctl_a_q <= ctl_p_q;
    end
  end

  assign prod_ext = ACC_W'(prod_q);

  always_comb begin
    acc_d = acc_q;
    if (ctl_p_q.valid) begin
      if (ctl_p_q.first) begin
        acc_d = prod_ext;
      end else begin
        acc_d = acc_q + prod_ext;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= rd_a_i * rd_b_i;
    acc_q  <= acc_d;
  end

  // arithmetic shift truncates toward minus infinity, then clamp to 32 bits
  assign shifted = acc_q >>> FRAC_BITS;
  assign hi_bits = shifted[ACC_W-1:DATA_W-1];
  assign fits    = (&hi_bits) | ~(|hi_bits);

  always_comb begin
    if (fits) begin
      sat_value = shifted[DATA_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      sat_value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  assign done_valid_o       = ctl_a_q.valid & ctl_a_q.acc_last;
  assign done_o.out_row     = ctl_a_q.row;
  assign done_o.out_col     = ctl_a_q.col;
  assign done_o.out_value   = sat_value;
  assign done_o.last        = ctl_a_q.last;
  assign done_o.error       = 1'b0;

endmodule

`default_nettype wire

// ===== src/matrix_multiply_engine.sv =====
// matrix_multiply_engine: top level, element stores, sequencer, output register
// depends on mme_pkg and mme_mac
//
// usage:
//   command channel: start with item_i (kind, row, col, value) is taken at a
//   clock edge where busy is low. kinds write an element of A or B, or run
//   the product A x B. writes may follow each other in every cycle while
//   busy is low. a write outside the configured shape stores nothing and
//   gives one error result in the cycle after it was taken.
//   configuration channel: cfg_valid_i/cfg_ready_o with cfg_index_i and
//   cfg_data_i sets rows_a, inner_size and cols_b; ready is high while idle.
//   a compute transaction holds busy until its total product elements are
//   shown, where n is the inner size and total = min(rows*cols, 64). each
//   product element sums n terms: one multiply-accumulate per cycle fed by
//   one read port of each store. elements are shown in row-major order,
//   the final one with last set. busy falls in the cycle that shows the
//   final element.
//   results sit on result_o for one cycle with result_valid_o; the receiver
//   has no stall, every result is taken in the cycle it is shown.
//   reset: registers return to 4, sequencer idles; store contents are
//   undefined until written.
`default_nettype none

module matrix_multiply_engine import mme_pkg::*; #(
  parameter int unsigned MAX_DIM   = 8,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start,
  output logic                      busy,
  input  wire mme_in_t              item_i,
  output logic                      result_valid_o,
  output mme_out_t                  result_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned TOT_W  = (2 * DIM_W > CNT_W) ? 2 * DIM_W : CNT_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] r);
    logic [DIM_W-1:0] d;
    if (r == '0) begin
      d = DIM_W'(1);
    end else if (r > MAX_DIM) begin
      d = DIM_W'(MAX_DIM);
    end else begin
      d = DIM_W'(r);
    end
    return d;
  endfunction

  state_e                   state_d, state_q;
  logic [CFG_W-1:0]         rows_q, inner_q, cols_q;
  logic [DIM_W-1:0]         dim_m, dim_n, dim_p;
  logic [TOT_W-1:0]         mp, mp_cap;
  logic [CNT_W-1:0]         total;
  logic [IDX_W-1:0]         i_d, i_q, j_d, j_q, k_d, k_q;
  logic [CNT_W-1:0]         elem_d, elem_q;
  logic                     k_last, j_last, elem_last;
  logic                     accept, is_write, oob, we_a, we_b;
  logic [ADDR_W-1:0]        wr_addr, a_addr, b_addr;
  logic signed [DATA_W-1:0] a_mem [DEPTH];
  logic signed [DATA_W-1:0] b_mem [DEPTH];
  logic signed [DATA_W-1:0] a_rd_q, b_rd_q;
  mac_ctl_t                 ctl_iss, ctl_rd_q;
  logic                     mac_valid;
  mme_out_t                 mac_res;
  logic                     res_valid_d, res_valid_q;
  mme_out_t                 res_d, res_q;

  assign dim_m  = eff_dim(rows_q);
  assign dim_n  = eff_dim(inner_q);
  assign dim_p  = eff_dim(cols_q);
  assign mp     = TOT_W'(dim_m) * TOT_W'(dim_p);
  assign mp_cap = TOT_W'(MAX_RESULTS);
  assign total  = (mp > mp_cap) ? CNT_W'(mp_cap) : CNT_W'(mp);

  assign busy        = ~state_q[0];
  assign cfg_ready_o = ~busy;
  assign accept      = start & ~busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= CFG_RESET;
      inner_q <= CFG_RESET;
      cols_q  <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_ROWS_A: rows_q  <= cfg_data_i;
        CFG_INNER:  inner_q <= cfg_data_i;
        CFG_COLS_B: cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // element writes and bounds check
  always_comb begin
    is_write = 1'b0;
    oob      = 1'b0;
    case (item_i.kind)
      KIND_WR_A: begin
        is_write = 1'b1;
        oob      = (item_i.row >= dim_m) || (item_i.col >= dim_n);
      end
      KIND_WR_B: begin
        is_write = 1'b1;
        oob      = (item_i.row >= dim_n) || (item_i.col >= dim_p);
      end
      default: ;
    endcase
  end

  assign we_a    = accept & is_write & ~oob & (item_i.kind == KIND_WR_A);
  assign we_b    = accept & is_write & ~oob & (item_i.kind == KIND_WR_B);
  assign wr_addr = ADDR_W'(item_i.row) * ADDR_W'(MAX_DIM) + ADDR_W'(item_i.col);
  assign a_addr  = ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q);
  assign b_addr  = ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q);

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      a_mem[wr_addr] <= item_i.value;
    end
    a_rd_q <= a_mem[a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) begin
      b_mem[wr_addr] <= item_i.value;
    end
    b_rd_q <= b_mem[b_addr];
  end

  // sequencer over product elements and dot product terms
  assign k_last    = (k_q == IDX_W'(dim_n - DIM_W'(1)));
  assign j_last    = (j_q == IDX_W'(dim_p - DIM_W'(1)));
  assign elem_last = (elem_q == total - CNT_W'(1));

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    elem_d  = elem_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && item_i.kind == KIND_COMPUTE) begin
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
          elem_d  = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (k_last) begin
          k_d    = '0;
          elem_d = elem_q + CNT_W'(1);
          if (j_last) begin
            j_d = '0;
            i_d = i_q + IDX_W'(1);
          end else begin
            j_d = j_q + IDX_W'(1);
          end
          if (elem_last) begin
            state_d = S_DRAIN;
          end
        end else begin
          k_d = k_q + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (mac_valid && mac_res.last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      elem_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      elem_q  <= elem_d;
    end
  end

  assign ctl_iss.valid    = (state_q == S_RUN);
  assign ctl_iss.first    = (k_q == '0);
  assign ctl_iss.acc_last = k_last;
  assign ctl_iss.last     = elem_last;
  assign ctl_iss.row      = POS_W'(i_q);
  assign ctl_iss.col      = POS_W'(j_q);

  // control aligned with registered store reads
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_rd_q <= '0;
    end else begin
      ctl_rd_q <= ctl_iss;
    end
  end

  mme_mac #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_a_i       (a_rd_q),
    .rd_b_i       (b_rd_q),
    .ctl_i        (ctl_rd_q),
    .done_valid_o (mac_valid),
    .done_o       (mac_res)
  );

  // output register, error results and product elements never coincide
  always_comb begin
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (accept && is_write && oob) begin
      res_valid_d     = 1'b1;
      res_d.out_row   = item_i.row;
      res_d.out_col   = item_i.col;
      res_d.out_value = '0;
      res_d.last      = 1'b0;
      res_d.error     = 1'b1;
    end else if (mac_valid) begin
      res_valid_d = 1'b1;
      res_d       = mac_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

// ===== src/mme_checker.sv =====
// mme_checker: port-level checks of the engine's command and result timing
// depends on mme_pkg; bound to matrix_multiply_engine at the end of this file
`default_nettype none

module mme_checker import mme_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire mme_in_t  item_i,
  input wire logic     result_valid_o,
  input wire mme_out_t result_o
);

  // error results only come in the cycle after a write transaction was taken
  a_err_after_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.error |->
      $past(start && !busy && (item_i.kind == KIND_WR_A || item_i.kind == KIND_WR_B)))
    else $error("error result without a preceding write");

  // product elements only come out of a running compute
  a_prod_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.error |-> $past(busy))
    else $error("product element outside a compute run");

  // busy rises only after a compute command
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && item_i.kind == KIND_COMPUTE))
    else $error("busy without a compute command");

  // busy falls exactly when the final element is shown
  a_busy_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o && result_o.last && !result_o.error)
    else $error("compute run ended without its final element");

endmodule

bind matrix_multiply_engine mme_checker u_mme_checker (.*);

`default_nettype wire
